// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assertion macros
// concurrent checks that drop out of synthesis builds
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define FHG_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fhg assertion failed");

`define FHG_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("fhg reset assertion failed");

`else

`define FHG_ASSERT(label, clk, rst_n, prop)

`define FHG_ASSERT_RST(label, clk, prop)

`endif

`endif

// ----- rtl/fhg_pkg.sv -----
// ---------------------------------------------------------------------------
// fhg_pkg
// shared types and constants of the ipv4 fragment header generator
// ---------------------------------------------------------------------------
`default_nettype none

package fhg_pkg;

  localparam logic [15:0] HDR_BYTES  = 16'd60;
  localparam logic [7:0]  VER_IHL    = 8'h4F;
  localparam logic [7:0]  TTL_RESET  = 8'd64;
  localparam logic [7:0]  TOS_RESET  = 8'd0;
  localparam int          CFG_IDX_W  = 8;

  localparam logic [CFG_IDX_W-1:0] REG_TOS = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TTL = 8'd1;

  // header word picked for the checksum adder
  typedef enum logic [3:0] {
    W_TOS    = 4'd0,
    W_ID     = 4'd1,
    W_TTL    = 4'd2,
    W_SRC_HI = 4'd3,
    W_SRC_LO = 4'd4,
    W_DST_HI = 4'd5,
    W_DST_LO = 4'd6,
    W_TLEN   = 4'd7,
    W_FO     = 4'd8
  } word_sel_t;

  typedef struct packed {
    logic      load;
    logic      add;
    logic      from_base;
    word_sel_t sel;
    logic      save_base;
    logic      emit;
  } fhg_cmd_t;

  typedef struct packed {
    logic last;
  } fhg_sts_t;

  typedef struct packed {
    logic [15:0] datagram_len;
    logic [15:0] identification;
    logic        more_fragments;
    logic [12:0] fragment_offset;
    logic [7:0]  hdr_protocol;
    logic [15:0] header_checksum;
    logic [31:0] hdr_source;
    logic [31:0] hdr_destination;
    logic [15:0] payload_start;
    logic [10:0] payload_bytes;
    logic        last_fragment;
  } frag_t;

endpackage

`default_nettype wire

// ----- rtl/fhg_if.sv -----
// ---------------------------------------------------------------------------
// fhg channel interfaces
// request, fragment and register write channels with valid/ready
// ---------------------------------------------------------------------------
`default_nettype none

interface fhg_req_if;
  logic        valid;
  logic        ready;
  logic [15:0] payload_length;
  logic [7:0]  protocol_number;
  logic [31:0] source_address;
  logic [31:0] destination_address;

  modport source (output valid, payload_length, protocol_number, source_address,
                  destination_address, input ready);
  modport sink   (input valid, payload_length, protocol_number, source_address,
                  destination_address, output ready);
endinterface

interface fhg_frag_if;
  logic        valid;
  logic        ready;
  logic [15:0] datagram_len;
  logic [15:0] identification;
  logic        more_fragments;
  logic [12:0] fragment_offset;
  logic [7:0]  hdr_protocol;
  logic [15:0] header_checksum;
  logic [31:0] hdr_source;
  logic [31:0] hdr_destination;
  logic [15:0] payload_start;
  logic [10:0] payload_bytes;
  logic        last_fragment;

  modport source (output valid, datagram_len, identification, more_fragments,
                  fragment_offset, hdr_protocol, header_checksum, hdr_source,
                  hdr_destination, payload_start, payload_bytes, last_fragment,
                  input ready);
  modport sink   (input valid, datagram_len, identification, more_fragments,
                  fragment_offset, hdr_protocol, header_checksum, hdr_source,
                  hdr_destination, payload_start, payload_bytes, last_fragment,
                  output ready);
endinterface

interface fhg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [fhg_pkg::CFG_IDX_W-1:0]  reg_index;
  logic [7:0]                     wdata;

  modport source (output valid, reg_index, wdata, input ready);
  modport sink   (input valid, reg_index, wdata, output ready);
endinterface

`default_nettype wire

// ----- rtl/fhg_ctrl.sv -----
// ---------------------------------------------------------------------------
// fhg_ctrl
// sequencer: header word sums per request and per fragment, output slot
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fhg_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  output logic                   out_valid,
  input  wire logic              out_ready,
  input  wire fhg_pkg::fhg_sts_t sts,
  output fhg_pkg::fhg_cmd_t      cmd
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_BASE = 4'b0010,
    ST_FRAG = 4'b0100,
    ST_SEND = 4'b1000
  } state_t;

  localparam logic [2:0] BASE_LAST = 3'd6;
  localparam logic [2:0] FRAG_LAST = 3'd1;

  state_t     state_r, state_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       send_ok;

  assign send_ok   = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    cmd           = '0;
    cmd.sel       = fhg_pkg::W_TOS;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          cnt_nxt   = '0;
          state_nxt = ST_BASE;
        end
      end
      ST_BASE: begin
        cmd.add = 1'b1;
        cmd.sel = fhg_pkg::word_sel_t'({1'b0, cnt_r});
        if (cnt_r == BASE_LAST) begin
          cmd.save_base = 1'b1;
          cnt_nxt       = '0;
          state_nxt     = ST_FRAG;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_FRAG: begin
        cmd.add       = 1'b1;
        cmd.from_base = (cnt_r == '0);
        cmd.sel       = (cnt_r == FRAG_LAST) ? fhg_pkg::W_FO : fhg_pkg::W_TLEN;
        if (cnt_r == FRAG_LAST) begin
          cnt_nxt   = '0;
          state_nxt = ST_SEND;
        end else begin
          cnt_nxt = cnt_r + 3'd1;
        end
      end
      ST_SEND: begin
        if (send_ok) begin
          cmd.emit  = 1'b1;
          state_nxt = sts.last ? ST_IDLE : ST_FRAG;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
        cnt_nxt   = '0;
      end
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `FHG_ASSERT(a_emit_slot_free, clk, rst_n, cmd.emit |-> (!out_valid_r || out_ready))
  `FHG_ASSERT(a_load_to_base, clk, rst_n, cmd.load |=> (state_r == ST_BASE && cnt_r == 3'd0))
  `FHG_ASSERT(a_last_to_idle, clk, rst_n, (cmd.emit && sts.last) |=> in_ready)
  `FHG_ASSERT_RST(a_reset_no_out, clk, !rst_n |=> !out_valid_r)

endmodule

`default_nettype wire

// ----- rtl/fhg_datapath.sv -----
// ---------------------------------------------------------------------------
// fhg_datapath
// request registers, fragment walk, one's complement adder, output register
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module fhg_datapath #(
  parameter int MAX_FRAGMENT_PAYLOAD = 1440
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire fhg_pkg::fhg_cmd_t                 cmd,
  output fhg_pkg::fhg_sts_t                      sts,
  input  wire logic [15:0]                       req_length,
  input  wire logic [7:0]                        req_protocol,
  input  wire logic [31:0]                       req_source,
  input  wire logic [31:0]                       req_destination,
  input  wire logic                              cfg_we,
  input  wire logic [fhg_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [7:0]                        cfg_data,
  output fhg_pkg::frag_t                         frag
);

  localparam int CLAMPED = (MAX_FRAGMENT_PAYLOAD < 1024) ? 1024 :
                           (MAX_FRAGMENT_PAYLOAD > 1480) ? 1480 : MAX_FRAGMENT_PAYLOAD;
  localparam int CHUNK   = CLAMPED - (CLAMPED % 8);
  localparam logic [10:0] CHUNK_B = 11'(CHUNK);

  logic [7:0]  tos_r, ttl_r;
  logic [15:0] id_counter_r, id_r;
  logic [15:0] offset_r, remaining_r;
  logic [7:0]  proto_r;
  logic [31:0] src_r, dst_r;
  logic [15:0] acc_r, base_r;
  fhg_pkg::frag_t frag_r;

  logic        last;
  logic [10:0] bytes;
  logic [15:0] tlen, fo, word, addend;
  logic [16:0] raw_sum;
  logic [15:0] acc_nxt;

  assign last  = (remaining_r <= {5'b0, CHUNK_B});
  assign bytes = last ? remaining_r[10:0] : CHUNK_B;
  assign tlen  = fhg_pkg::HDR_BYTES + {5'b0, bytes};
  assign fo    = {2'b00, !last, offset_r[15:3]};
  assign sts.last = last;

  always_comb begin
    case (cmd.sel)
      fhg_pkg::W_TOS:    word = {fhg_pkg::VER_IHL, tos_r};
      fhg_pkg::W_ID:     word = id_r;
      fhg_pkg::W_TTL:    word = {ttl_r, proto_r};
      fhg_pkg::W_SRC_HI: word = src_r[31:16];
      fhg_pkg::W_SRC_LO: word = src_r[15:0];
      fhg_pkg::W_DST_HI: word = dst_r[31:16];
      fhg_pkg::W_DST_LO: word = dst_r[15:0];
      fhg_pkg::W_TLEN:   word = tlen;
      fhg_pkg::W_FO:     word = fo;
      default:           word = 16'h0000;
    endcase
  end

  // end-around carry add
  assign addend  = cmd.from_base ? base_r : acc_r;
  assign raw_sum = {1'b0, addend} + {1'b0, word};
  assign acc_nxt = raw_sum[15:0] + {15'b0, raw_sum[16]};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tos_r        <= fhg_pkg::TOS_RESET;
      ttl_r        <= fhg_pkg::TTL_RESET;
      id_counter_r <= '0;
      offset_r     <= '0;
      remaining_r  <= '0;
    end else begin
      if (cfg_we && cfg_index == fhg_pkg::REG_TOS) begin
        tos_r <= cfg_data;
      end
      if (cfg_we && cfg_index == fhg_pkg::REG_TTL) begin
        ttl_r <= cfg_data;
      end
      if (cmd.load) begin
        id_counter_r <= id_counter_r + 16'd1;
        offset_r     <= '0;
        remaining_r  <= req_length;
      end else if (cmd.emit) begin
        offset_r    <= offset_r + {5'b0, bytes};
        remaining_r <= remaining_r - {5'b0, bytes};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      id_r    <= id_counter_r;
      proto_r <= req_protocol;
      src_r   <= req_source;
      dst_r   <= req_destination;
      acc_r   <= '0;
    end else if (cmd.add) begin
      acc_r <= acc_nxt;
    end
    if (cmd.save_base) begin
      base_r <= acc_nxt;
    end
    if (cmd.emit) begin
      frag_r.datagram_len    <= tlen;
      frag_r.identification  <= id_r;
      frag_r.more_fragments  <= !last;
      frag_r.fragment_offset <= offset_r[15:3];
      frag_r.hdr_protocol    <= proto_r;
      frag_r.header_checksum <= ~acc_r;
      frag_r.hdr_source      <= src_r;
      frag_r.hdr_destination <= dst_r;
      frag_r.payload_start   <= offset_r;
      frag_r.payload_bytes   <= bytes;
      frag_r.last_fragment   <= last;
    end
  end

  assign frag = frag_r;

  `FHG_ASSERT(a_full_chunk, clk, rst_n, (cmd.emit && !last) |=> frag_r.payload_bytes == CHUNK_B)
  `FHG_ASSERT(a_last_drains, clk, rst_n, (cmd.emit && last) |=> remaining_r == 16'd0)
  `FHG_ASSERT(a_tlen_match, clk, rst_n, cmd.emit |=> frag_r.datagram_len == fhg_pkg::HDR_BYTES + {5'b0, frag_r.payload_bytes})

endmodule

`default_nettype wire

// ----- rtl/ipv4_fragment_header_generator.sv -----
// a request transfer loads the request registers, the base state sums the seven
// request words, then per fragment the fragment state adds the two fragment words
// through the single checksum adder and the send state emits once the output is
// free; the block takes no new request until its last fragment is emitted
// synchronous active-low reset: id counter cleared, tos 0, ttl 64, output empty
// ---------------------------------------------------------------------------
// ipv4_fragment_header_generator
// splits a send request into ipv4 fragment headers with checksum
// ---------------------------------------------------------------------------
`default_nettype none

module ipv4_fragment_header_generator #(
  parameter int MAX_FRAGMENT_PAYLOAD = 1440
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  fhg_req_if.sink     in_req,
  fhg_frag_if.source  out_frag,
  fhg_cfg_if.sink     cfg_wr
);

  fhg_pkg::fhg_cmd_t cmd;
  fhg_pkg::fhg_sts_t sts;
  fhg_pkg::frag_t    frag;
  logic              in_ready;
  logic              out_valid;

  assign cfg_wr.ready = 1'b1;
  assign in_req.ready = in_ready;
  assign out_frag.valid = out_valid;

  fhg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_req.valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_frag.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  fhg_datapath #(
    .MAX_FRAGMENT_PAYLOAD (MAX_FRAGMENT_PAYLOAD)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .req_length      (in_req.payload_length),
    .req_protocol    (in_req.protocol_number),
    .req_source      (in_req.source_address),
    .req_destination (in_req.destination_address),
    .cfg_we          (cfg_wr.valid),
    .cfg_index       (cfg_wr.reg_index),
    .cfg_data        (cfg_wr.wdata),
    .frag            (frag)
  );

  assign out_frag.datagram_len    = frag.datagram_len;
  assign out_frag.identification  = frag.identification;
  assign out_frag.more_fragments  = frag.more_fragments;
  assign out_frag.fragment_offset = frag.fragment_offset;
  assign out_frag.hdr_protocol    = frag.hdr_protocol;
  assign out_frag.header_checksum = frag.header_checksum;
  assign out_frag.hdr_source      = frag.hdr_source;
  assign out_frag.hdr_destination = frag.hdr_destination;
  assign out_frag.payload_start   = frag.payload_start;
  assign out_frag.payload_bytes   = frag.payload_bytes;
  assign out_frag.last_fragment   = frag.last_fragment;

endmodule

`default_nettype wire
